FILE: hw/rtl/lpb_pkg.sv
package lpb_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 16;
  localparam int unsigned FIRST_PRIME     = 2;
  localparam int unsigned PC_W            = 4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT_DIV,
    OP_REM_START,
    OP_NEXT_DIV,
    OP_DEC_CAND,
    OP_EMIT_HIT,
    OP_EMIT_NONE
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_NO_PRIME,
    C_SQ_GT,
    C_REM_BUSY,
    C_REM_ZERO,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic in_accept;
    logic no_prime;
    logic sq_gt;
    logic rem_busy;
    logic rem_zero;
    logic out_full;
  } status_t;

  function automatic ctrl_t uword(op_e o, cond_e c, int unsigned t);
    ctrl_t w;
    w.op     = o;
    w.cond   = c;
    w.target = PC_W'(t);
    return w;
  endfunction

  // Control store. A taken condition jumps to target, otherwise the next step.
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_W'(0):  w = uword(OP_ACCEPT,    C_NO_ACCEPT, 0);
      PC_W'(1):  w = uword(OP_NOP,       C_NO_PRIME,  11);
      PC_W'(2):  w = uword(OP_INIT_DIV,  C_NEVER,     0);
      PC_W'(3):  w = uword(OP_NOP,       C_SQ_GT,     9);
      PC_W'(4):  w = uword(OP_REM_START, C_NEVER,     0);
      PC_W'(5):  w = uword(OP_NOP,       C_REM_BUSY,  5);
      PC_W'(6):  w = uword(OP_NOP,       C_REM_ZERO,  8);
      PC_W'(7):  w = uword(OP_NEXT_DIV,  C_ALWAYS,    3);
      PC_W'(8):  w = uword(OP_DEC_CAND,  C_ALWAYS,    2);
      PC_W'(9):  w = uword(OP_EMIT_HIT,  C_OUT_FULL,  9);
      PC_W'(10): w = uword(OP_NOP,       C_ALWAYS,    0);
      PC_W'(11): w = uword(OP_EMIT_NONE, C_OUT_FULL,  11);
      PC_W'(12): w = uword(OP_NOP,       C_ALWAYS,    0);
      default:   w = uword(OP_NOP,       C_ALWAYS,    0);
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/lpb_rem.sv
// Restoring remainder, one quotient bit per cycle.
module lpb_rem #(
  parameter int unsigned VALUE_WIDTH = lpb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   busy_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] dvd_q, dvd_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(VALUE_WIDTH);
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      dvd_d = {dvd_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/lpb_seq.sv
// Step counter over the control store, with conditional jumps.
module lpb_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpb_pkg::status_t  status_i,
  output lpb_pkg::op_e      op_o
);

  logic [lpb_pkg::PC_W-1:0] pc_q, pc_d;
  lpb_pkg::ctrl_t           cw;
  logic                     taken;

  assign cw = lpb_pkg::ucode(pc_q);

  always_comb begin
    case (cw.cond)
      lpb_pkg::C_NEVER:     taken = 1'b0;
      lpb_pkg::C_ALWAYS:    taken = 1'b1;
      lpb_pkg::C_NO_ACCEPT: taken = !status_i.in_accept;
      lpb_pkg::C_NO_PRIME:  taken = status_i.no_prime;
      lpb_pkg::C_SQ_GT:     taken = status_i.sq_gt;
      lpb_pkg::C_REM_BUSY:  taken = status_i.rem_busy;
      lpb_pkg::C_REM_ZERO:  taken = status_i.rem_zero;
      lpb_pkg::C_OUT_FULL:  taken = status_i.out_full;
      default:              taken = 1'b1;
    endcase
    pc_d = taken ? cw.target : pc_q + lpb_pkg::PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = cw.op;

endmodule

FILE: hw/rtl/lpb_dp.sv
// Candidate, divisor and divisor-square registers plus the result register.
module lpb_dp #(
  parameter int unsigned VALUE_WIDTH = lpb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lpb_pkg::op_e           op_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] upper_limit_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] prime_value_o,
  output logic                   found_o,
  output logic [VALUE_WIDTH-1:0] cand_o,
  output logic [VALUE_WIDTH-1:0] div_o,
  output logic                   rem_start_o,
  input  logic                   rem_busy_i,
  input  logic [VALUE_WIDTH-1:0] rem_i,
  output lpb_pkg::status_t       status_o
);

  localparam int unsigned SW = VALUE_WIDTH + 2;

  logic [VALUE_WIDTH-1:0] cand_q, cand_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [SW-1:0]          sq_q, sq_d;
  logic                   no_prime_q, no_prime_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] prime_q, prime_d;
  logic                   found_q, found_d;
  logic                   accept;

  assign in_ready_o  = (op_i == lpb_pkg::OP_ACCEPT);
  assign accept      = in_ready_o && in_valid_i;
  assign rem_start_o = (op_i == lpb_pkg::OP_REM_START);

  always_comb begin
    cand_d      = cand_q;
    div_d       = div_q;
    sq_d        = sq_q;
    no_prime_d  = no_prime_q;
    out_valid_d = out_valid_q && !out_ready_i;
    prime_d     = prime_q;
    found_d     = found_q;
    case (op_i)
      lpb_pkg::OP_ACCEPT: begin
        if (accept) begin
          cand_d     = upper_limit_i - VALUE_WIDTH'(1);
          no_prime_d = (upper_limit_i <= VALUE_WIDTH'(lpb_pkg::FIRST_PRIME));
        end
      end
      lpb_pkg::OP_INIT_DIV: begin
        div_d = VALUE_WIDTH'(lpb_pkg::FIRST_PRIME);
        sq_d  = SW'(lpb_pkg::FIRST_PRIME * lpb_pkg::FIRST_PRIME);
      end
      lpb_pkg::OP_NEXT_DIV: begin
        // (d+1)^2 = d^2 + 2d + 1
        div_d = div_q + VALUE_WIDTH'(1);
        sq_d  = sq_q + ({2'b00, div_q} << 1) + SW'(1);
      end
      lpb_pkg::OP_DEC_CAND: begin
        cand_d = cand_q - VALUE_WIDTH'(1);
      end
      lpb_pkg::OP_EMIT_HIT: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          prime_d     = cand_q;
          found_d     = 1'b1;
        end
      end
      lpb_pkg::OP_EMIT_NONE: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          prime_d     = '0;
          found_d     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      no_prime_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      no_prime_q  <= no_prime_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
    found_q <= found_d;
  end

  assign status_o.in_accept = accept;
  assign status_o.no_prime  = no_prime_q;
  assign status_o.sq_gt     = sq_q > {2'b00, cand_q};
  assign status_o.rem_busy  = rem_busy_i;
  assign status_o.rem_zero  = (rem_i == '0);
  assign status_o.out_full  = out_valid_q;

  assign out_valid_o   = out_valid_q;
  assign prime_value_o = prime_q;
  assign found_o       = found_q;
  assign cand_o        = cand_q;
  assign div_o         = div_q;

endmodule

FILE: hw/rtl/largest_prime_below_top.sv
// Channel  Handshake           Payload
// in       in_valid_i/ready_o  upper_limit_i
// out      out_valid_o/ready_i prime_value_o, found_o
//
// One query at a time. Each divisor test is done by the bit-serial remainder unit;
// a query tests its candidates in turn, then makes a last bound check and gives the result.
// A limit of 2 or less raises out_valid_o after the accept, with found_o low.
// Reset (rst_ni low) returns the step counter to the accept step and empties the output.
// The next query is taken while a result waits; a stalled result holds the last step.
module largest_prime_below_top #(
  parameter int unsigned VALUE_WIDTH = lpb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] upper_limit_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] prime_value_o,
  output logic                   found_o
);

  lpb_pkg::op_e           op;
  lpb_pkg::status_t       status;
  logic [VALUE_WIDTH-1:0] cand;
  logic [VALUE_WIDTH-1:0] div;
  logic                   rem_start;
  logic                   rem_busy;
  logic [VALUE_WIDTH-1:0] rem;

  lpb_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  lpb_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .upper_limit_i (upper_limit_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prime_value_o (prime_value_o),
    .found_o       (found_o),
    .cand_o        (cand),
    .div_o         (div),
    .rem_start_o   (rem_start),
    .rem_busy_i    (rem_busy),
    .rem_i         (rem),
    .status_o      (status)
  );

  lpb_rem #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (cand),
    .divisor_i  (div),
    .busy_o     (rem_busy),
    .rem_o      (rem)
  );

`ifndef ASSERT_OFF
  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rem_busy)
    else $error("input taken while remainder unit busy");

  a_rem_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rem_busy) |-> $past(op == lpb_pkg::OP_REM_START))
    else $error("remainder unit started outside its step");

  a_hit_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (prime_value_o >= VALUE_WIDTH'(lpb_pkg::FIRST_PRIME)))
    else $error("found result below first prime");

  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (prime_value_o == '0))
    else $error("miss result not zero");
`endif

endmodule
